// ===== src/sfla_pkg.sv =====
// shared types, codes and constants of the slot free-list allocator
// no dependencies; imported by every other file of the block
package sfla_pkg;

  // field widths of the channels
  localparam int OPC_W    = 2;
  localparam int IDX_W    = 6;
  localparam int ENTRY_W  = 32;
  localparam int STATUS_W = 2;
  localparam int HW_W     = 7;

  // defaults of the top-level parameters
  localparam int SLOTS_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // widest slot index over the parameter range (4096 slots)
  localparam int MAX_SW = 12;

  // occupancy scan works on groups of this many slots
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_B    = 3;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {
    K_ADD,
    K_REMOVE,
    K_READ,
    K_BAD
  } kind_e;

  // classified command handed from the front queue to the back end
  typedef struct packed {
    kind_e               kind;
    logic                in_range;
    logic [IDX_W-1:0]    slot;
    logic [ENTRY_W-1:0]  data;
  } cmd_t;

  // result of the two-level occupancy scan
  typedef struct packed {
    logic              free_found;
    logic [MAX_SW-1:0] free_idx;
    logic              occ_found;
    logic [MAX_SW-1:0] top_idx;
  } scan_t;

endpackage

// ===== src/sfla_if.sv =====
// valid/ready channel interfaces of the slot free-list allocator
// depends on sfla_pkg for the field widths
interface sfla_in_if;
  import sfla_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [IDX_W-1:0]   slot_index;
  logic [ENTRY_W-1:0] entry_data;

  modport source (output valid, output opcode, output slot_index, output entry_data,
                  input ready);
  modport sink   (input valid, input opcode, input slot_index, input entry_data,
                  output ready);
endinterface

interface sfla_out_if;
  import sfla_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    result_index;
  logic [ENTRY_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic [HW_W-1:0]     high_water;

  modport source (output valid, output result_index, output read_value, output status,
                  output high_water, input ready);
  modport sink   (input valid, input result_index, input read_value, input status,
                  input high_water, output ready);
endinterface

// ===== src/sfla_front.sv =====
// front end: accepts commands, classifies them and queues them for the back end
// depends on sfla_pkg and sfla_in_if
module sfla_front #(
  parameter int SLOTS = sfla_pkg::SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfla_in_if.sink       cmd_i,
  output sfla_pkg::cmd_t head_o,
  output logic          head_valid_o,
  input  logic          pop_i
);
  import sfla_pkg::*;

  cmd_t       cls;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  always_comb begin
    cls.slot     = cmd_i.slot_index;
    cls.data     = cmd_i.entry_data;
    cls.in_range = (int'(cmd_i.slot_index) < SLOTS);
    case (cmd_i.opcode)
      OP_ADD:    cls.kind = K_ADD;
      OP_REMOVE: cls.kind = K_REMOVE;
      OP_READ:   cls.kind = K_READ;
      default:   cls.kind = K_BAD;
    endcase
  end

  assign cmd_i.ready  = (cnt_q != 2'd2);
  assign push         = cmd_i.valid && cmd_i.ready;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count lost a push");

endmodule

// ===== src/sfla_scan.sv =====
// two-level priority scan over the occupancy bits: group encoders registered,
// then a pick across groups; depends on sfla_pkg
module sfla_scan #(
  parameter int SLOTS = sfla_pkg::SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [SLOTS-1:0]          occ_i,
  input  logic [$clog2(SLOTS)-1:0]  clr_idx_i,
  input  logic                      clr_en_i,
  output sfla_pkg::scan_t           scan_o
);
  import sfla_pkg::*;

  localparam int GROUPS = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD    = GROUPS * GROUP_SIZE;

  logic [SLOTS-1:0]   clr_mask;
  logic [PAD-1:0]     free_vec, occ_vec;
  logic               gf_d [GROUPS];
  logic               go_d [GROUPS];
  logic [GROUP_B-1:0] gfo_d [GROUPS];
  logic [GROUP_B-1:0] gto_d [GROUPS];
  logic               gf_q [GROUPS];
  logic               go_q [GROUPS];
  logic [GROUP_B-1:0] gfo_q [GROUPS];
  logic [GROUP_B-1:0] gto_q [GROUPS];

  always_comb begin
    clr_mask = '0;
    if (clr_en_i) clr_mask[clr_idx_i] = 1'b1;
  end

  // padding counts as neither free nor occupied
  always_comb begin
    free_vec = '0;
    occ_vec  = '0;
    free_vec[SLOTS-1:0] = ~occ_i;
    occ_vec[SLOTS-1:0]  = occ_i & ~clr_mask;
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gf_d[g]  = |free_vec[g*GROUP_SIZE +: GROUP_SIZE];
      go_d[g]  = |occ_vec[g*GROUP_SIZE +: GROUP_SIZE];
      gfo_d[g] = '0;
      gto_d[g] = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (free_vec[g*GROUP_SIZE + b]) gfo_d[g] = GROUP_B'(b);
      end
      for (int b = 0; b < GROUP_SIZE; b++) begin
        if (occ_vec[g*GROUP_SIZE + b]) gto_d[g] = GROUP_B'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < GROUPS; g++) begin
        gf_q[g]  <= gf_d[g];
        go_q[g]  <= go_d[g];
        gfo_q[g] <= gfo_d[g];
        gto_q[g] <= gto_d[g];
      end
    end
  end

  // lowest group with a free slot, highest group with an occupied slot
  always_comb begin
    scan_o = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (gf_q[g]) begin
        scan_o.free_found = 1'b1;
        scan_o.free_idx   = (MAX_SW'(g) << GROUP_B) | MAX_SW'(gfo_q[g]);
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      if (go_q[g]) begin
        scan_o.occ_found = 1'b1;
        scan_o.top_idx   = (MAX_SW'(g) << GROUP_B) | MAX_SW'(gto_q[g]);
      end
    end
  end

endmodule

// ===== src/sfla_back.sv =====
// back end: occupancy bits, high-water mark, slot memory and result register
// depends on sfla_pkg and sfla_out_if
module sfla_back #(
  parameter int SLOTS      = sfla_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = sfla_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfla_pkg::cmd_t            head_i,
  input  logic                      head_valid_i,
  output logic                      pop_o,
  input  sfla_pkg::scan_t           scan_i,
  output logic                      scan_en_o,
  output logic [SLOTS-1:0]          occ_o,
  output logic [$clog2(SLOTS)-1:0]  clr_idx_o,
  output logic                      clr_en_o,
  sfla_out_if.source                rsp_o
);
  import sfla_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int MW = $clog2(SLOTS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_q, state_d;
  cmd_t                  cmd_q;
  logic [SLOTS-1:0]      occ_q, occ_d;
  logic [MW-1:0]         mark_q, mark_d;
  logic [DATA_WIDTH-1:0] mem [SLOTS];
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  mem_we;
  logic [SW-1:0]         slot_sw, free_sw, top_sw;
  logic                  hit;

  logic                  out_valid_q;
  logic [IDX_W-1:0]      res_idx_q, res_idx;
  logic [ENTRY_W-1:0]    res_val_q, res_val;
  logic [STATUS_W-1:0]   res_st_q, res_st;
  logic [HW_W-1:0]       res_hw_q;

  // a command is taken only when the result register will be free for it
  assign pop_o     = (state_q == S_IDLE) && head_valid_i && (!out_valid_q || rsp_o.ready);
  assign scan_en_o = pop_o;
  assign occ_o     = occ_q;
  assign clr_idx_o = SW'(head_i.slot);
  assign clr_en_o  = (head_i.kind == K_REMOVE);
  assign state_d   = (state_q == S_IDLE) ? pop_o : S_IDLE;

  always_comb begin
    occ_d   = occ_q;
    mark_d  = mark_q;
    mem_we  = 1'b0;
    res_idx = cmd_q.slot;
    res_val = '0;
    res_st  = ST_OK;
    slot_sw = SW'(cmd_q.slot);
    free_sw = SW'(scan_i.free_idx);
    top_sw  = SW'(scan_i.top_idx);
    hit     = cmd_q.in_range && occ_q[slot_sw];
    if (state_q == S_EXEC) begin
      case (cmd_q.kind)
        K_ADD: begin
          if (scan_i.free_found) begin
            mem_we         = 1'b1;
            occ_d[free_sw] = 1'b1;
            res_idx        = IDX_W'(free_sw);
            if (MW'(free_sw) + MW'(1) > mark_q) mark_d = MW'(free_sw) + MW'(1);
          end else begin
            res_st  = ST_FULL;
            res_idx = '0;
          end
        end
        K_REMOVE: begin
          if (hit) begin
            occ_d[slot_sw] = 1'b0;
            // top slot freed: fall to the next occupied slot below it
            if (int'(cmd_q.slot) + 1 == int'(mark_q)) begin
              mark_d = scan_i.occ_found ? MW'(top_sw) + MW'(1) : '0;
            end
          end else begin
            res_st = ST_BAD;
          end
        end
        K_READ: begin
          if (hit) res_val = ENTRY_W'(rd_q);
          else     res_st  = ST_BAD;
        end
        default: res_st = ST_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[free_sw] <= DATA_WIDTH'(cmd_q.data);
    if (pop_o)  rd_q <= mem[SW'(head_i.slot)];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= head_i;
    if (state_q == S_EXEC) begin
      res_idx_q <= res_idx;
      res_val_q <= res_val;
      res_st_q  <= res_st;
      res_hw_q  <= HW_W'(mark_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      mark_q  <= mark_d;
      if (state_q == S_EXEC) out_valid_q <= 1'b1;
      else if (rsp_o.ready)  out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_index = res_idx_q;
  assign rsp_o.read_value   = res_val_q;
  assign rsp_o.status       = res_st_q;
  assign rsp_o.high_water   = res_hw_q;

  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(mark_q) <= SLOTS) else $error("high-water mark beyond capacity");
  a_mark_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q != '0 |-> occ_q[SW'(mark_q - MW'(1))]) else $error("slot below mark is free");
  a_exec_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !out_valid_q) else $error("result register busy at execute");
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> out_valid_q && state_q == S_IDLE) else $error("execute lost result");

endmodule

// ===== src/slot_free_list_allocator.sv =====
// top level of the slot free-list allocator: front queue, occupancy scan, back end
// depends on sfla_pkg, sfla_if, sfla_front, sfla_scan and sfla_back
//
//  channel  dir  handshake            payload
//  cmd_i    in   valid/ready          opcode, slot_index, entry_data
//  rsp_o    out  valid/ready          result_index, read_value, status, high_water
//
// per transaction the occupancy scan registers its group encoders (and the slot
// memory is read), then the command executes and fills the result register; a
// new one enters the back end only after that, once the result register is free
// a two-entry front queue keeps accepting, until it is full, while a result waits to be taken
// reset clears the occupancy bits and the mark at once; no clearing pass
module slot_free_list_allocator #(
  parameter int SLOTS      = sfla_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = sfla_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfla_in_if.sink     cmd_i,
  sfla_out_if.source  rsp_o
);
  import sfla_pkg::*;

  localparam int SW = $clog2(SLOTS);

  cmd_t             head;
  logic             head_valid;
  logic             pop;
  scan_t            scan;
  logic             scan_en;
  logic [SLOTS-1:0] occ;
  logic [SW-1:0]    clr_idx;
  logic             clr_en;

  sfla_front #(.SLOTS(SLOTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  sfla_scan #(.SLOTS(SLOTS)) u_scan (
    .clk_i     (clk_i),
    .en_i      (scan_en),
    .occ_i     (occ),
    .clr_idx_i (clr_idx),
    .clr_en_i  (clr_en),
    .scan_o    (scan)
  );

  sfla_back #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .scan_i       (scan),
    .scan_en_o    (scan_en),
    .occ_o        (occ),
    .clr_idx_o    (clr_idx),
    .clr_en_o     (clr_en),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for slot_free_list_allocator: directed and random commands
// depends on sfla_pkg and the sfla_in_if / sfla_out_if interfaces of the block
`timescale 1ns / 100ps

module testbench;
  import sfla_pkg::*;

  localparam int SLOTS      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int RAND_ITEMS = 850;
  localparam int CALM_ITEMS = 100;
  localparam int LIMIT      = 200000;

  // the fourth opcode value is unused by the block
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [ENTRY_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [HW_W-1:0]     mark;
  } outcome_t;

  class slot_scoreboard;
    bit                 occ[SLOTS];
    logic [ENTRY_W-1:0] store[SLOTS];
    int                 mark;
    outcome_t           outcome_q[$];
    int                 errors;
    int                 n_done, n_full, n_bad, n_read_ok, peak_mark;

    function new();
      foreach (occ[i]) occ[i] = 1'b0;
      mark   = 0;
      errors = 0;
      n_done = 0; n_full = 0; n_bad = 0; n_read_ok = 0; peak_mark = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // apply one accepted transaction to the local allocator copy
    function void note_cmd(logic [OPC_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [ENTRY_W-1:0] data);
      outcome_t r;
      bit       placed;
      int       i;
      r.index  = idx;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
        OP_ADD: begin
          placed = 1'b0;
          for (i = 0; i < mark && !placed; i++) begin
            if (!occ[i]) begin
              store[i] = data;
              occ[i]   = 1'b1;
              r.index  = i[IDX_W-1:0];
              placed   = 1'b1;
            end
          end
          if (!placed) begin
            if (mark < SLOTS) begin
              store[mark] = data;
              occ[mark]   = 1'b1;
              r.index     = mark[IDX_W-1:0];
              mark++;
            end else begin
              r.status = ST_FULL;
              r.index  = '0;
            end
          end
        end
        OP_REMOVE: begin
          if (!occ[idx]) begin
            r.status = ST_BAD;
          end else begin
            occ[idx] = 1'b0;
            // freeing the top slot drops the mark past trailing holes
            if (int'(idx) + 1 == mark) begin
              while (mark > 0 && !occ[mark-1]) mark--;
            end
          end
        end
        OP_READ: begin
          if (!occ[idx]) r.status = ST_BAD;
          else r.value = store[idx];
        end
        default: r.status = ST_BAD;
      endcase
      r.mark = mark[HW_W-1:0];
      outcome_q.push_back(r);
    endfunction

    function void check(outcome_t got);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("response with nothing outstanding (index %0d status %0d)",
                         got.index, got.status));
        return;
      end
      want = outcome_q.pop_front();
      n_done++;
      if (want.status == ST_FULL) n_full++;
      if (want.status == ST_BAD) n_bad++;
      if (want.status == ST_OK && want.value != '0) n_read_ok++;
      if (want.mark > peak_mark) peak_mark = want.mark;
      if (got.index !== want.index)
        report($sformatf("result_index %0d, expected %0d", got.index, want.index));
      if (got.value !== want.value)
        report($sformatf("read_value %h, expected %h", got.value, want.value));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.mark !== want.mark)
        report($sformatf("high_water %0d, expected %0d", got.mark, want.mark));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   cycles;
  int   stall_left;
  slot_scoreboard sb;

  sfla_in_if  cmd ();
  sfla_out_if rsp ();

  slot_free_list_allocator #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    rst_ni         = 1'b0;
    cmd.valid      = 1'b0;
    cmd.opcode     = OP_ADD;
    cmd.slot_index = '0;
    cmd.entry_data = '0;
    rsp.ready      = 1'b0;
    idle_on        = 1'b0;
    cycles         = 0;
    stall_left     = 0;
    sb             = new();
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               sb.outcome_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side: check each transaction, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready)
        sb.check('{rsp.result_index, rsp.read_value, rsp.status, rsp.high_water});
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                      input logic [ENTRY_W-1:0] data);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid      <= 1'b1;
    cmd.opcode     <= op;
    cmd.slot_index <= idx;
    cmd.entry_data <= data;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    sb.note_cmd(op, idx, data);
  endtask

  // mostly slots below the mark, often the top one, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_slot();
    if (sb.mark > 0 && $urandom_range(0, 3) == 0) return IDX_W'(sb.mark - 1);
    if (sb.mark > 0 && $urandom_range(0, 3) != 0) return IDX_W'($urandom_range(0, sb.mark - 1));
    return IDX_W'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ENTRY_W'($urandom);
    endcase
  endfunction

  initial begin
    int                 add_pct [8];
    int                 n;
    int                 phase;
    logic [OPC_W-1:0]   op;

    add_pct = '{85, 20, 60, 92, 10, 55, 75, 40};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: data extremes, holes, mark drops, free slots, unused opcode
    idle_on = 1'b1;
    send(OP_ADD,    6'd0,  32'h0000_0000);
    send(OP_ADD,    6'd0,  32'hFFFF_FFFF);
    send(OP_ADD,    6'd63, 32'hA5A5_5A5A);
    send(OP_ADD,    6'd0,  32'h1234_5678);
    send(OP_READ,   6'd1,  32'h0);
    send(OP_READ,   6'd63, 32'hFFFF_FFFF);
    send(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send(OP_REMOVE, 6'd1,  32'h0);
    send(OP_REMOVE, 6'd1,  32'h0);
    send(OP_READ,   6'd1,  32'h0);
    send(OP_ADD,    6'd5,  32'hDEAD_BEEF);
    send(OP_READ,   6'd1,  32'h0);
    send(OP_REMOVE, 6'd2,  32'h0);
    send(OP_REMOVE, 6'd3,  32'h0);
    send(OP_REMOVE, 6'd0,  32'h0);
    send(OP_REMOVE, 6'd1,  32'h0);
    send(OP_REMOVE, 6'd0,  32'h0);
    send(OP_READ,   6'd0,  32'h0);
    send(OP_ADD,    6'd0,  32'h8000_0001);
    send(OP_READ,   6'd0,  32'h0);
    send(OP_UNUSED, 6'd0,  32'h0);

    // random: phases alternate between filling and draining the store
    for (n = 0; n < RAND_ITEMS; n++) begin
      phase = (n * 8) / RAND_ITEMS;
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n >= RAND_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      if ($urandom_range(0, 99) < 3) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < add_pct[phase]) op = OP_ADD;
      else if ($urandom_range(0, 1) == 0) op = OP_REMOVE;
      else op = OP_READ;
      send(op, (op == OP_ADD) ? IDX_W'($urandom) : pick_slot(), pick_data());
    end
    cmd.valid <= 1'b0;

    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("checked %0d transactions: %0d full, %0d error status, %0d nonzero reads",
             sb.n_done, sb.n_full, sb.n_bad, sb.n_read_ok);
    $display("peak high-water mark %0d of %0d slots, %0d mismatches", sb.peak_mark, SLOTS,
             sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
